FILE: sv/draw_batch_binning_defines.svh
// assertion helpers for the draw batch binning block
`ifndef DRAW_BATCH_BINNING_DEFINES_SVH
`define DRAW_BATCH_BINNING_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DBB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dbb assertion failed");

// next-cycle implication
`define DBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dbb assertion failed");

`else

`define DBB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define DBB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/dbb_pkg.sv
package dbb_pkg;

	localparam int MAX_BATCHES_DEF  = 32;
	localparam int TEXTURE_BITS_DEF = 16;

	// field widths
	localparam int TAG_BITS   = 16;
	localparam int COLOR_BITS = 32;
	localparam int CHAN_BITS  = 8;
	localparam int NUM_CHAN   = COLOR_BITS / CHAN_BITS;
	localparam int TOL_BITS   = 8;
	localparam int CNT_BITS   = 16;
	localparam int SLOT_BITS  = 5;

	// stream widths
	localparam int S_TDATA_W = TAG_BITS + COLOR_BITS;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 2;

	// request kind carried on s_tuser
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [TOL_BITS-1:0] TOL_RESET = 8'd30;
	localparam logic [CNT_BITS-1:0] VTX_LIMIT = 16'd65531;
	localparam logic [CNT_BITS-1:0] IDX_LIMIT = 16'd65529;
	localparam logic [CNT_BITS-1:0] VTX_STEP  = 16'd4;
	localparam logic [CNT_BITS-1:0] IDX_STEP  = 16'd6;

	// depth of the queue between front and back
	localparam int Q_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 table_full;
		logic                 opened_new;
		logic [CNT_BITS-1:0]  vtx_base;
		logic [SLOT_BITS-1:0] batch_slot;
	} res_t;

	function automatic logic colors_close(
		input logic [COLOR_BITS-1:0] a,
		input logic [COLOR_BITS-1:0] b,
		input logic [TOL_BITS-1:0]   tol
	);
		logic                 ok;
		logic [CHAN_BITS-1:0] ca;
		logic [CHAN_BITS-1:0] cb;
		logic [CHAN_BITS-1:0] d;
		ok = 1'b1;
		for (int c = 0; c < NUM_CHAN; c++) begin
			ca = a[c*CHAN_BITS +: CHAN_BITS];
			cb = b[c*CHAN_BITS +: CHAN_BITS];
			d  = (ca > cb) ? ca - cb : cb - ca;
			if (d > tol) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

FILE: sv/dbb_front.sv
module dbb_front
	import dbb_pkg::*;
#(
	parameter int TEXTURE_BITS = TEXTURE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_W-1:0]    s_tdata,
	input  logic                    s_tuser,
	output logic                    q_valid,
	output logic                    q_clear,
	output logic [TEXTURE_BITS-1:0] q_tex,
	output logic [COLOR_BITS-1:0]   q_color,
	input  logic                    q_pop
);

	localparam int QPW = $clog2(Q_DEPTH);
	localparam int QCW = $clog2(Q_DEPTH + 1);
	localparam logic [QCW-1:0] Q_FULL = QCW'(Q_DEPTH);

	logic [TEXTURE_BITS+TAG_BITS-1:0] tag_ext;
	logic                             push;

	logic                    ent_clear_q [Q_DEPTH];
	logic [TEXTURE_BITS-1:0] ent_tex_q   [Q_DEPTH];
	logic [COLOR_BITS-1:0]   ent_color_q [Q_DEPTH];
	logic [QPW-1:0]          wr_ptr_q;
	logic [QPW-1:0]          rd_ptr_q;
	logic [QCW-1:0]          cnt_q;

	// only the low texture bits take part in matching
	assign tag_ext = {{TEXTURE_BITS{1'b0}}, s_tdata[TAG_BITS-1:0]};

	assign s_tready = (cnt_q != Q_FULL);
	assign push     = s_tvalid && s_tready;

	assign q_valid = (cnt_q != '0);
	assign q_clear = ent_clear_q[rd_ptr_q];
	assign q_tex   = ent_tex_q[rd_ptr_q];
	assign q_color = ent_color_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_clear_q[wr_ptr_q] <= (s_tuser == OP_CLEAR);
			ent_tex_q[wr_ptr_q]   <= tag_ext[TEXTURE_BITS-1:0];
			ent_color_q[wr_ptr_q] <= s_tdata[TAG_BITS +: COLOR_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/dbb_back.sv
`include "draw_batch_binning_defines.svh"

module dbb_back
	import dbb_pkg::*;
#(
	parameter int MAX_BATCHES  = MAX_BATCHES_DEF,
	parameter int TEXTURE_BITS = TEXTURE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [TOL_BITS-1:0]     tolerance,
	input  logic                    q_valid,
	input  logic                    q_clear,
	input  logic [TEXTURE_BITS-1:0] q_tex,
	input  logic [COLOR_BITS-1:0]   q_color,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output res_t                    out_res
);

	localparam int SW = $clog2(MAX_BATCHES);
	localparam int CW = $clog2(MAX_BATCHES + 1);
	localparam int EW = TEXTURE_BITS + COLOR_BITS + 2 * CNT_BITS;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BATCHES);

	state_t state_q, state_d;

	logic [CW-1:0]           open_count_q;
	logic                    more_q;
	logic                    cmp_vld_q;
	logic                    out_valid_q;
	logic [TEXTURE_BITS-1:0] tex_q;
	logic [COLOR_BITS-1:0]   color_q;
	logic [SW-1:0]           idx_q;
	logic [SW-1:0]           cmp_idx_q;
	logic [EW-1:0]           rdata_q;
	res_t                    res_q;
	res_t                    out_res_q;

	// batch table: {texture, first color, index count, vertex count}
	logic [EW-1:0] mem_q [MAX_BATCHES];

	logic                    rd_en;
	logic                    wr_en;
	logic [SW-1:0]           wr_addr;
	logic [EW-1:0]           wr_data;
	logic                    out_load;
	logic [CNT_BITS-1:0]     rd_vcnt;
	logic [CNT_BITS-1:0]     rd_icnt;
	logic [COLOR_BITS-1:0]   rd_color;
	logic [TEXTURE_BITS-1:0] rd_tex;
	logic                    hit;
	logic                    tbl_full;
	logic [SW-1:0]           new_slot;
	logic [CW-1:0]           oc_m1;
	logic [SW+SLOT_BITS-1:0] hit_ext;
	logic [SW+SLOT_BITS-1:0] new_ext;

	assign rd_vcnt  = rdata_q[CNT_BITS-1:0];
	assign rd_icnt  = rdata_q[2*CNT_BITS-1:CNT_BITS];
	assign rd_color = rdata_q[2*CNT_BITS +: COLOR_BITS];
	assign rd_tex   = rdata_q[EW-1 -: TEXTURE_BITS];

	assign hit = cmp_vld_q && (rd_tex == tex_q) && (rd_vcnt < VTX_LIMIT) &&
		(rd_icnt < IDX_LIMIT) && colors_close(rd_color, color_q, tolerance);

	assign tbl_full = (open_count_q == MAX_CNT);
	assign new_slot = open_count_q[SW-1:0];
	assign oc_m1    = open_count_q - 1'b1;

	// slot numbers are reported in five bits
	assign hit_ext = {{SLOT_BITS{1'b0}}, cmp_idx_q};
	assign new_ext = {{SLOT_BITS{1'b0}}, new_slot};

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		out_load = 1'b0;
		wr_addr  = new_slot;
		wr_data  = {tex_q, color_q, IDX_STEP, VTX_STEP};
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = q_clear ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = more_q && !hit;
				if (hit) begin
					wr_en   = 1'b1;
					wr_addr = cmp_idx_q;
					wr_data = {tex_q, rd_color, rd_icnt + IDX_STEP, rd_vcnt + VTX_STEP};
					state_d = ST_DONE;
				end else if (!more_q) begin
					// nothing matched: open a slot unless the table is full
					wr_en   = !tbl_full;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_count_q <= '0;
			more_q       <= 1'b0;
			cmp_vld_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				cmp_vld_q <= 1'b0;
				if (q_clear) begin
					open_count_q <= '0;
				end else begin
					more_q <= (open_count_q != '0);
				end
			end
			if (state_q == ST_SCAN) begin
				cmp_vld_q <= more_q;
				if (!hit && !more_q && !tbl_full) begin
					open_count_q <= open_count_q + 1'b1;
				end
				// oldest slot read or search finished
				if (idx_q == '0 || state_d == ST_DONE) begin
					more_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tex_q   <= q_tex;
			color_q <= q_color;
			idx_q   <= oc_m1[SW-1:0];
			res_q   <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (more_q) begin
				cmp_idx_q <= idx_q;
				idx_q     <= idx_q - 1'b1;
			end
			if (hit) begin
				res_q.batch_slot <= hit_ext[SLOT_BITS-1:0];
				res_q.vtx_base   <= rd_vcnt;
				res_q.opened_new <= 1'b0;
				res_q.table_full <= 1'b0;
			end else if (!more_q) begin
				res_q.batch_slot <= tbl_full ? '0 : new_ext[SLOT_BITS-1:0];
				res_q.vtx_base   <= '0;
				res_q.opened_new <= !tbl_full;
				res_q.table_full <= tbl_full;
			end
		end
		if (out_load) begin
			out_res_q <= res_q;
		end
	end

	// single-port table: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[idx_q];
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`DBB_ASSERT_IMPLIES(a_scan_in_range, clk, arst_n, (state_q == ST_SCAN) && more_q,
		idx_q < open_count_q)
	`DBB_ASSERT_NEXT(a_open_grows, clk, arst_n,
		(state_q == ST_SCAN) && !hit && !more_q && !tbl_full,
		open_count_q == $past(open_count_q) + 1'b1)
	`DBB_ASSERT_IMPLIES(a_full_drop, clk, arst_n, out_load && res_q.table_full, tbl_full)
	`DBB_ASSERT_IMPLIES(a_out_from_done, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == ST_DONE)

endmodule

FILE: sv/draw_batch_binning.sv
// channel  | dir | valid/ready        | payload
// config   | in  | cfg_wr_en          | cfg_wr_data = match tolerance
// request  | in  | s_tvalid/s_tready  | s_tdata = texture_tag, quad_color; s_tuser = op
// result   | out | m_tvalid/m_tready  | m_tdata = batch_slot, vtx_base; m_tuser = flags
//
// a quad visits the batches starting from the newest one;
// the single-port batch table is walked one slot per cycle
// a clear request skips the table search
// reset empties the queue and the open count; table entries are written when a batch opens or grows
// a two-entry queue keeps taking requests while the search runs or a result waits
module draw_batch_binning
	import dbb_pkg::*;
#(
	parameter int MAX_BATCHES  = MAX_BATCHES_DEF,
	parameter int TEXTURE_BITS = TEXTURE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [TOL_BITS-1:0]  cfg_wr_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // texture_tag, quad_color
	input  logic                 s_tuser,  // op
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // batch_slot, vtx_base, zero fill
	output logic [M_TUSER_W-1:0] m_tuser   // opened_new, table_full
);

	logic [TOL_BITS-1:0]     tol_q;
	logic                    q_valid;
	logic                    q_clear;
	logic [TEXTURE_BITS-1:0] q_tex;
	logic [COLOR_BITS-1:0]   q_color;
	logic                    q_pop;
	res_t                    res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	dbb_front #(
		.TEXTURE_BITS(TEXTURE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_clear (q_clear),
		.q_tex   (q_tex),
		.q_color (q_color),
		.q_pop   (q_pop)
	);

	dbb_back #(
		.MAX_BATCHES (MAX_BATCHES),
		.TEXTURE_BITS(TEXTURE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tolerance(tol_q),
		.q_valid  (q_valid),
		.q_clear  (q_clear),
		.q_tex    (q_tex),
		.q_color  (q_color),
		.q_pop    (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {{(M_TDATA_W - SLOT_BITS - CNT_BITS){1'b0}}, res.vtx_base, res.batch_slot};
	assign m_tuser = {res.table_full, res.opened_new};

endmodule

FILE: tb/sv/tb_draw_batch_binning.sv
`timescale 1ns / 1ps

module tb_draw_batch_binning;
	import dbb_pkg::*;

	localparam logic OP_QUAD    = 1'b0;
	localparam int   DRAIN_WAIT = MAX_BATCHES_DEF + 8;
	localparam int   HOLD_LEN   = 400;
	localparam int   PHASE_LEN  = 252;

	class binning_scoreboard;
		logic [TOL_BITS-1:0]   tol;
		int                    open_cnt;
		logic [TAG_BITS-1:0]   slot_tag [MAX_BATCHES_DEF];
		logic [COLOR_BITS-1:0] slot_color [MAX_BATCHES_DEF];
		logic [CNT_BITS-1:0]   slot_vtx [MAX_BATCHES_DEF];
		logic [CNT_BITS-1:0]   slot_idx [MAX_BATCHES_DEF];
		res_t                  expected_bins [$];
		int                    errors;

		function new();
			tol      = TOL_RESET;
			open_cnt = 0;
			errors   = 0;
		endfunction

		function bit near_color(logic [COLOR_BITS-1:0] a, logic [COLOR_BITS-1:0] b);
			logic [CHAN_BITS-1:0] ca;
			logic [CHAN_BITS-1:0] cb;
			for (int c = 0; c < NUM_CHAN; c++) begin
				ca = a[c*CHAN_BITS +: CHAN_BITS];
				cb = b[c*CHAN_BITS +: CHAN_BITS];
				if (((ca > cb) ? ca - cb : cb - ca) > tol) begin
					return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		// bins one accepted request and queues the result it must produce
		function void note_request(logic op, logic [TAG_BITS-1:0] tag,
				logic [COLOR_BITS-1:0] col);
			res_t r;
			int   s;
			bit   hit;
			r   = '0;
			hit = 1'b0;
			if (op == OP_CLEAR) begin
				open_cnt = 0;
			end else begin
				// newest batch first
				for (s = open_cnt - 1; s >= 0; s--) begin
					if (slot_tag[s] == tag && slot_vtx[s] < VTX_LIMIT &&
							slot_idx[s] < IDX_LIMIT && near_color(slot_color[s], col)) begin
						hit = 1'b1;
						break;
					end
				end
				if (!hit) begin
					if (open_cnt < MAX_BATCHES_DEF) begin
						s             = open_cnt;
						slot_tag[s]   = tag;
						slot_color[s] = col;
						slot_vtx[s]   = '0;
						slot_idx[s]   = '0;
						open_cnt++;
						r.opened_new = 1'b1;
						hit          = 1'b1;
					end else begin
						r.table_full = 1'b1;
					end
				end
				if (hit) begin
					r.batch_slot = s[SLOT_BITS-1:0];
					r.vtx_base   = slot_vtx[s];
					slot_vtx[s]  = slot_vtx[s] + VTX_STEP;
					slot_idx[s]  = slot_idx[s] + IDX_STEP;
				end
			end
			expected_bins.insert(expected_bins.size(), r);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
			res_t exp_r;
			res_t got;
			got            = '0;
			got.batch_slot = data[SLOT_BITS-1:0];
			got.vtx_base   = data[SLOT_BITS +: CNT_BITS];
			got.opened_new = user[0];
			got.table_full = user[1];
			if (expected_bins.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: result with no request pending: slot %0d vstart %0d new %0b full %0b",
						$realtime, got.batch_slot, got.vtx_base, got.opened_new,
						got.table_full);
				end
				return;
			end
			exp_r = expected_bins.pop_front();
			if (got.batch_slot !== exp_r.batch_slot || got.vtx_base !== exp_r.vtx_base ||
					got.opened_new !== exp_r.opened_new || got.table_full !== exp_r.table_full) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: mismatch exp slot %0d vstart %0d new %0b full %0b", $realtime,
						exp_r.batch_slot, exp_r.vtx_base, exp_r.opened_new, exp_r.table_full);
					$display("%0t:          got slot %0d vstart %0d new %0b full %0b", $realtime,
						got.batch_slot, got.vtx_base, got.opened_new, got.table_full);
				end
			end
		endfunction

		function int pending();
			return expected_bins.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [TOL_BITS-1:0]  cfg_wr_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	logic hold_rx = 1'b0;
	int   rx_stall_pct = 0;
	int   tx_idle_pct = 0;

	logic [TAG_BITS-1:0]   tag_pool [8];
	logic [COLOR_BITS-1:0] color_pool [4];

	binning_scoreboard sb = new();

	draw_batch_binning u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_rx) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_request(s_tuser, s_tdata[TAG_BITS-1:0], s_tdata[S_TDATA_W-1:TAG_BITS]);
			end
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata, m_tuser);
			end
		end
	end

	task automatic send_request(input logic op, input logic [TAG_BITS-1:0] tag,
			input logic [COLOR_BITS-1:0] col);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {col, tag};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_tolerance(input logic [TOL_BITS-1:0] v);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.tol = v;
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input logic [TOL_BITS-1:0] tol,
			input int n, input bit pressure);
		logic [TAG_BITS-1:0]   tag;
		logic [COLOR_BITS-1:0] col;
		logic [COLOR_BITS-1:0] base;
		set_tolerance(tol);
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		foreach (tag_pool[i]) tag_pool[i] = TAG_BITS'($urandom);
		foreach (color_pool[i]) color_pool[i] = $urandom;
		for (int i = 0; i < n; i++) begin
			if (pressure && i == 40) begin
				// receiver holds off while requests keep coming
				fork
					begin
						hold_rx <= 1'b1;
						repeat (HOLD_LEN) @(posedge clk);
						hold_rx <= 1'b0;
					end
				join_none
			end
			tag  = ($urandom_range(99) < 80) ? tag_pool[$urandom_range(7)] : TAG_BITS'($urandom);
			base = color_pool[$urandom_range(3)];
			case ($urandom_range(9))
				0, 1, 2: col = $urandom;
				3, 4: col = base;
				default: begin
					col = base;
					for (int c = 0; c < NUM_CHAN; c++) begin
						col[c*CHAN_BITS +: CHAN_BITS] = base[c*CHAN_BITS +: CHAN_BITS] +
							CHAN_BITS'($urandom_range(80)) - CHAN_BITS'(40);
					end
				end
			endcase
			send_request(($urandom_range(79) == 0) ? OP_CLEAR : OP_QUAD, tag, col);
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		logic [COLOR_BITS-1:0] fill_color;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// channel distance right at and just past the reset tolerance
		send_request(OP_CLEAR, 16'h0000, 32'h0000_0000);
		send_request(OP_QUAD, 16'h0000, 32'h0000_0000);
		send_request(OP_QUAD, 16'h0000, 32'h1E1E_1E1E);
		send_request(OP_QUAD, 16'h0000, 32'h1F00_0000);
		send_request(OP_QUAD, 16'h0000, 32'h0000_1F00);
		send_request(OP_QUAD, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(OP_QUAD, 16'h0000, 32'h0000_0000);
		send_request(OP_QUAD, 16'hFFFF, 32'hE1E1_E1E1);
		send_request(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);

		// fill every slot, then a quad that finds no room, then one that still matches
		fill_color = $urandom;
		for (int i = 0; i < MAX_BATCHES_DEF; i++) begin
			send_request(OP_QUAD, TAG_BITS'(16'h0100 + i), fill_color);
		end
		send_request(OP_QUAD, 16'hABCD, fill_color);
		send_request(OP_QUAD, 16'h0100, fill_color);
		send_request(OP_CLEAR, 16'h0000, 32'h0000_0000);
		s_tvalid <= 1'b0;

		run_phase(0, 0, 8'd255, PHASE_LEN, 1'b1);
		run_phase(75, 0, 8'd0, PHASE_LEN, 1'b0);
		run_phase(0, 75, TOL_BITS'($urandom_range(1, 254)), PHASE_LEN, 1'b0);
		run_phase(23, 23, TOL_RESET, PHASE_LEN, 1'b0);

		wait_drained();
		if (sb.errors + sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/dbb_pkg.sv
sv/dbb_front.sv
sv/dbb_back.sv
sv/draw_batch_binning.sv
tb/sv/tb_draw_batch_binning.sv
